[hw/rtl/otq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otq_pkg
// Shared types, widths and constants for the object track qualifier.
// ----------------------------------------------------------------------------
package otq_pkg;

  localparam int SLOT_W    = 5;
  localparam int PATTERN_W = 3;
  localparam int SOURCE_W  = 2;
  localparam int VAL_W     = 16;
  localparam int LIMIT_W   = 15;
  localparam int ID_W      = 8;
  localparam int TIME_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 32;

  localparam int DEF_NUM_SLOTS = 32;

  localparam logic [ID_W-1:0]   ID_NONE  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Register reset values (1/128 units)
  localparam logic [LIMIT_W-1:0] RST_LAT_SPEED_LIMIT = 15'd384;
  localparam logic [VAL_W-1:0]   RST_MIN_LONG_SPEED  = 16'hFF80;  // -1.0
  localparam logic [VAL_W-1:0]   RST_FRONT_RANGE     = 16'd16640; // 130.0
  localparam logic [VAL_W-1:0]   RST_REAR_RANGE      = 16'hD300;  // -90.0
  localparam logic [VAL_W-1:0]   RST_MIN_EGO_SPEED   = 16'hFF80;  // -1.0

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAT_SPEED_LIMIT = 3'd0,
    CFG_MIN_LONG_SPEED  = 3'd1,
    CFG_FRONT_RANGE     = 3'd2,
    CFG_REAR_RANGE      = 3'd3,
    CFG_MIN_EGO_SPEED   = 3'd4
  } cfg_idx_t;

  localparam logic [PATTERN_W-1:0] PAT_PRECEDING  = 3'd0;
  localparam logic [PATTERN_W-1:0] PAT_ONCOMING   = 3'd1;
  localparam logic [PATTERN_W-1:0] PAT_STOPPED    = 3'd2;
  localparam logic [PATTERN_W-1:0] PAT_STATIONARY = 3'd3;

  localparam logic [SOURCE_W-1:0] SRC_RADAR_VISION = 2'd0;
  localparam logic [SOURCE_W-1:0] SRC_VISION_ONLY  = 2'd1;

  typedef struct packed {
    logic [LIMIT_W-1:0]      lat_speed_limit;
    logic signed [VAL_W-1:0] min_long_speed;
    logic signed [VAL_W-1:0] front_range;
    logic signed [VAL_W-1:0] rear_range;
    logic signed [VAL_W-1:0] min_ego_speed;
  } cfg_t;

  typedef struct packed {
    logic                    obj_valid;
    logic [PATTERN_W-1:0]    motion_pattern;
    logic [SOURCE_W-1:0]     fusion_source;
    logic signed [VAL_W-1:0] lat_speed;
    logic signed [VAL_W-1:0] long_speed;
    logic signed [VAL_W-1:0] long_position;
    logic signed [VAL_W-1:0] ego_speed;
  } obj_t;

  // One slot entry in the track memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] cnt;
  } entry_t;

endpackage

[hw/rtl/otq_qualify.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otq_qualify
// Window and pattern checks deciding whether one object qualifies.
// ----------------------------------------------------------------------------
module otq_qualify
  import otq_pkg::*;
(
  input  obj_t cfg_obj,
  input  cfg_t cfg_regs,
  output logic ok
);

  logic [VAL_W:0] lat_mag;
  logic           pattern_ok;
  logic           window_ok;

  always_comb begin
    // 17 bits so the most negative speed gives 32768
    if (cfg_obj.lat_speed[VAL_W-1]) begin
      lat_mag = (VAL_W+1)'(0) - {cfg_obj.lat_speed[VAL_W-1], cfg_obj.lat_speed};
    end else begin
      lat_mag = {1'b0, cfg_obj.lat_speed};
    end

    pattern_ok = (cfg_obj.motion_pattern == PAT_PRECEDING) ||
                 (cfg_obj.motion_pattern == PAT_ONCOMING) ||
                 (cfg_obj.motion_pattern == PAT_STOPPED) ||
                 ((cfg_obj.motion_pattern == PAT_STATIONARY) &&
                  ((cfg_obj.fusion_source == SRC_RADAR_VISION) ||
                   (cfg_obj.fusion_source == SRC_VISION_ONLY)));

    window_ok = (cfg_obj.ego_speed >= cfg_regs.min_ego_speed) &&
                (lat_mag < {2'b00, cfg_regs.lat_speed_limit}) &&
                (cfg_obj.long_speed > cfg_regs.min_long_speed) &&
                (cfg_obj.long_position < cfg_regs.front_range) &&
                (cfg_obj.long_position > cfg_regs.rear_range);

    ok = cfg_obj.obj_valid && pattern_ok && window_ok;
  end

endmodule

[hw/rtl/object_track_qualifier_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_track_qualifier_unit
// Per-slot qualification of fused objects with saturating track time.
// ----------------------------------------------------------------------------
//  port group | dir | contents
//  in_*       | in  | one object for one slot per transfer
//  out_*      | out | slot state after the update, one per input transfer
//  cfg_*      | in  | register writes, index + data, no read-back
//
// One transfer per cycle sustained while the output is not stalled. The slot
// memory is read when an object is taken and written back as it leaves the
// update stage; a back-to-back same-slot update is forwarded from the write.
// Reset clears the tracked flags directly; no clearing pass is needed.
// A stalled output holds the pipe; the input still takes one transfer while
// the output register waits.
// ----------------------------------------------------------------------------
module object_track_qualifier_unit
  import otq_pkg::*;
#(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // slot[4:0] obj_valid[5] motion_pattern[8:6] fusion_source[10:9]
  // lat_speed[26:11] long_speed[42:27] long_position[58:43] obj_id[66:59]
  // ego_speed[82:67], zero fill above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_slot[4:0] tracked[5] track_time[21:6] track_id[29:22], zero fill above
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [VAL_W-1:0]      cfg_wdata
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int AW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  // configuration
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lat_speed_limit <= RST_LAT_SPEED_LIMIT;
      cfg_r.min_long_speed  <= RST_MIN_LONG_SPEED;
      cfg_r.front_range     <= RST_FRONT_RANGE;
      cfg_r.rear_range      <= RST_REAR_RANGE;
      cfg_r.min_ego_speed   <= RST_MIN_EGO_SPEED;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LAT_SPEED_LIMIT: cfg_r.lat_speed_limit <= cfg_wdata[LIMIT_W-1:0];
        CFG_MIN_LONG_SPEED:  cfg_r.min_long_speed  <= cfg_wdata;
        CFG_FRONT_RANGE:     cfg_r.front_range     <= cfg_wdata;
        CFG_REAR_RANGE:      cfg_r.rear_range      <= cfg_wdata;
        CFG_MIN_EGO_SPEED:   cfg_r.min_ego_speed   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input unpack
  logic [SLOT_W-1:0] in_slot;
  logic [ID_W-1:0]   in_obj_id;
  obj_t              in_obj;
  logic              in_ok;
  logic              in_range;
  logic [AW-1:0]     in_slot_ext;
  logic [IDX_W-1:0]  in_addr;

  assign in_slot               = in_tdata[4:0];
  assign in_obj.obj_valid      = in_tdata[5];
  assign in_obj.motion_pattern = in_tdata[8:6];
  assign in_obj.fusion_source  = in_tdata[10:9];
  assign in_obj.lat_speed      = in_tdata[26:11];
  assign in_obj.long_speed     = in_tdata[42:27];
  assign in_obj.long_position  = in_tdata[58:43];
  assign in_obj_id             = in_tdata[66:59];
  assign in_obj.ego_speed      = in_tdata[82:67];

  assign in_range    = (int'(in_slot) < NUM_SLOTS);
  assign in_slot_ext = AW'(in_slot);
  assign in_addr     = in_slot_ext[IDX_W-1:0];

  otq_qualify u_qualify (
    .cfg_obj  (in_obj),
    .cfg_regs (cfg_r),
    .ok       (in_ok)
  );

  // handshake
  logic out_valid_r;
  logic s1_valid_r;
  logic advance;
  logic s1_go;
  logic in_acc;

  assign advance   = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  // update stage
  logic [SLOT_W-1:0] s1_slot_r;
  logic [IDX_W-1:0]  s1_addr_r;
  logic              s1_ok_r;
  logic              s1_inr_r;
  logic [ID_W-1:0]   s1_id_r;
  logic              s1_fwd_r;
  entry_t            fwd_data_r;
  entry_t            rd_data_r;
  entry_t            cur;
  entry_t            new_entry;
  logic              old_trk;
  logic              wr_en;

  entry_t               mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] trk_r;

  always_comb begin
    cur     = s1_fwd_r ? fwd_data_r : rd_data_r;
    old_trk = trk_r[s1_addr_r];
    if (old_trk) begin
      new_entry.id  = cur.id;
      new_entry.cnt = (cur.cnt == TIME_MAX) ? cur.cnt : cur.cnt + TIME_W'(1);
    end else begin
      new_entry.id  = s1_id_r;
      new_entry.cnt = TIME_W'(1);
    end
    wr_en = s1_go && s1_inr_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en && s1_ok_r) begin
      mem[s1_addr_r] <= new_entry;
    end
    if (in_acc) begin
      rd_data_r <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r <= '0;
    end else if (wr_en) begin
      trk_r[s1_addr_r] <= s1_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_slot_r  <= in_slot;
      s1_addr_r  <= in_addr;
      s1_ok_r    <= in_ok;
      s1_inr_r   <= in_range;
      s1_id_r    <= in_obj_id;
      // the read above misses a write-back to the same slot at this edge
      s1_fwd_r   <= wr_en && s1_ok_r && (in_addr == s1_addr_r);
      fwd_data_r <= new_entry;
    end
  end

  // output register
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_tracked_r;
  logic [TIME_W-1:0] out_time_r;
  logic [ID_W-1:0]   out_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_slot_r <= s1_slot_r;
      if (s1_inr_r && s1_ok_r) begin
        out_tracked_r <= 1'b1;
        out_time_r    <= new_entry.cnt;
        out_id_r      <= new_entry.id;
      end else begin
        out_tracked_r <= 1'b0;
        out_time_r    <= '0;
        out_id_r      <= ID_NONE;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_id_r, out_time_r, out_tracked_r, out_slot_r};

endmodule
